@@ rtl/timeseries_dod_xor_encoder_core_defines.svh @@
// assertion macros shared by the encoder rtl
`ifndef TIMESERIES_DOD_XOR_ENCODER_CORE_DEFINES_SVH
`define TIMESERIES_DOD_XOR_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTH
`define TDX_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("tdx assertion failed");
`define TDX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdx assertion failed");
`define TDX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdx assertion failed");
`else
`define TDX_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define TDX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TDX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/tdx_pkg.sv @@
// shared types, constants and bit-count functions of the encoder
`timescale 1ns / 1ps
`default_nettype none
package tdx_pkg;
	localparam int TIME_W = 32;
	localparam int VALUE_W = 64;
	localparam int SPAN_W = 16;
	localparam int FIELD_W = 64;
	localparam int LEN_W = 7;
	localparam int DOD_W = TIME_W + 2;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd7200;

	typedef struct packed {
		logic [FIELD_W-1:0] bits;
		logic [LEN_W-1:0] len;
	} field_t;

	typedef struct packed {
		field_t f2;
		field_t f1;
		field_t f0;
		logic [1:0] last_idx;
		logic opens;
	} job_t;

	function automatic logic [3:0] lzc8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) n = 4'(7 - i);
		end
		return n;
	endfunction

	function automatic logic [6:0] lzc64(input logic [63:0] x);
		logic [6:0] n;
		logic [3:0] b;
		n = 7'd64;
		for (int j = 0; j < 8; j++) begin
			b = lzc8(x[j*8 +: 8]);
			if (x[j*8 +: 8] != 8'd0) n = 7'((7 - j) * 8) + {3'b000, b};
		end
		return n;
	endfunction

	function automatic logic [63:0] rev64(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[i] = x[63 - i];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/timeseries_dod_xor_encoder_core.sv @@
// top level of the timestamp and value stream encoder
`timescale 1ns / 1ps
`default_nettype none
// Each accepted sample yields two or three right-aligned bit fields, one per
// output transaction, tlast on the final one. A sample that continues a block
// passes the front part as take, delta-of-delta and xor, zero counts and
// queue write; one that opens a block instead waits on the one-bit-per-cycle
// remainder unit that finds the offset within the span, then writes its job.
// The back part sends one field per cycle while the output is ready, from a job
// queue of QUEUE_DEPTH entries, so the output side may stall without holding up
// the front until the queue fills. block_span is written through the cfg channel,
// which is always ready; a span of zero acts as one.
module timeseries_dod_xor_encoder_core #(
	parameter int QUEUE_DEPTH = tdx_pkg::QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [15:0] cfg_data,      // block_span
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // timestamp[31:0], value_bits[95:32]
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [71:0] m_axis_tdata,       // field_bits[63:0], field_length[70:64], zero pad
	output logic m_axis_tuser,              // opens_block
	output logic m_axis_tlast               // last
);
	import tdx_pkg::*;

	logic [SPAN_W-1:0] span_q;
	logic push;
	job_t push_job;
	logic push_ready;
	logic pop;
	logic head_valid;
	job_t head;
	logic [FIELD_W-1:0] field_bits;
	logic [LEN_W-1:0] field_length;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= SPAN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			span_q <= cfg_data;
		end
	end

	tdx_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.span(span_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.timestamp(s_axis_tdata[31:0]),
		.value_bits(s_axis_tdata[95:32]),
		.push(push),
		.push_job(push_job),
		.push_ready(push_ready)
	);

	tdx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.push_ready(push_ready),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	tdx_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.field_bits(field_bits),
		.field_length(field_length),
		.opens_block(m_axis_tuser),
		.last(m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, field_length, field_bits};
endmodule
`default_nettype wire

@@ rtl/tdx_div.sv @@
// iterative remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module tdx_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [tdx_pkg::TIME_W-1:0] dividend,
	input  wire logic [tdx_pkg::SPAN_W-1:0] divisor,
	output logic done,
	output logic busy,
	output logic [tdx_pkg::SPAN_W-1:0] rem
);
	import tdx_pkg::*;
	`include "timeseries_dod_xor_encoder_core_defines.svh"

	localparam int CNT_W = $clog2(TIME_W);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0] dvd_q;
	logic [SPAN_W-1:0] dsr_q;
	logic [SPAN_W-1:0] rem_q;
	logic [SPAN_W:0] trial;

	assign trial = {rem_q, dvd_q[TIME_W-1]};
	assign done = busy_q && (cnt_q == '0);
	assign busy = busy_q;
	assign rem = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(TIME_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, dsr_q}) rem_q <= SPAN_W'(trial - {1'b0, dsr_q});
			else rem_q <= trial[SPAN_W-1:0];
		end
	end

	`TDX_ASSERT_NEXT(a_div_no_restart, clk, arst_n, busy_q && !done, busy_q)
endmodule
`default_nettype wire

@@ rtl/tdx_front.sv @@
// front part: takes samples, keeps the stream state and builds field jobs
`timescale 1ns / 1ps
`default_nettype none
module tdx_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [tdx_pkg::SPAN_W-1:0] span,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [tdx_pkg::TIME_W-1:0] timestamp,
	input  wire logic [tdx_pkg::VALUE_W-1:0] value_bits,
	output logic push,
	output tdx_pkg::job_t push_job,
	input  wire logic push_ready
);
	import tdx_pkg::*;
	`include "timeseries_dod_xor_encoder_core_defines.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_CNT  = 3'd2;
	localparam logic [2:0] ST_PUSH = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OPEN = 3'd5;

	logic [2:0] state_q;

	logic have_block_q;
	logic [TIME_W-1:0] block_start_q;
	logic [TIME_W-1:0] prev_time_q;
	logic [TIME_W:0] prev_delta_q;
	logic [VALUE_W-1:0] prev_value_q;
	logic win_valid_q;
	logic [5:0] win_lead_q;
	logic [LEN_W-1:0] win_len_q;

	logic [TIME_W-1:0] t_q;
	logic [VALUE_W-1:0] v_q;
	logic [DOD_W-1:0] dod_q;
	logic [VALUE_W-1:0] x_q;
	logic x_zero_q;
	logic [LEN_W-1:0] lz_q;
	logic [LEN_W-1:0] tz_q;
	logic [LEN_W-1:0] len_q;

	logic [SPAN_W-1:0] span_eff;
	logic [TIME_W-1:0] since_start;
	logic opens;
	logic [TIME_W:0] delta;
	logic [DOD_W-1:0] dod;
	logic [LEN_W-1:0] lz_c;
	logic [LEN_W-1:0] tz_c;
	logic win_hit;
	logic [TIME_W-1:0] aligned;

	logic div_start;
	logic div_done;
	logic div_busy;
	logic [SPAN_W-1:0] div_rem;

	assign span_eff = (span == '0) ? SPAN_W'(1) : span;
	assign since_start = t_q - block_start_q;
	assign opens = !have_block_q || (since_start >= {{(TIME_W-SPAN_W){1'b0}}, span_eff});
	assign delta = {1'b0, t_q} - {1'b0, prev_time_q};
	assign dod = {delta[TIME_W], delta} - {prev_delta_q[TIME_W], prev_delta_q};
	assign lz_c = lzc64(x_q);
	assign tz_c = lzc64(rev64(x_q));
	assign win_hit = win_valid_q && ({1'b0, win_lead_q} == lz_q) && (win_len_q == len_q);
	assign aligned = t_q - {{(TIME_W-SPAN_W){1'b0}}, div_rem};

	assign in_ready = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_EVAL) && opens;
	assign push = ((state_q == ST_PUSH) || (state_q == ST_OPEN)) && push_ready;

	tdx_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(t_q),
		.divisor(span_eff),
		.done(div_done),
		.busy(div_busy),
		.rem(div_rem)
	);

	always_comb begin
		push_job = '0;
		if (state_q == ST_OPEN) begin
			push_job.f0 = '{bits: {{(FIELD_W-TIME_W){1'b0}}, aligned}, len: LEN_W'(64)};
			push_job.f1 = '{bits: {{(FIELD_W-SPAN_W){1'b0}}, div_rem}, len: LEN_W'(16)};
			push_job.f2 = '{bits: v_q, len: LEN_W'(64)};
			push_job.last_idx = 2'd2;
			push_job.opens = 1'b1;
		end else begin
			priority if (dod_q == '0) begin
				push_job.f0 = '{bits: '0, len: LEN_W'(1)};
			end else if ((&dod_q[DOD_W-1:6]) || !(|dod_q[DOD_W-1:6])) begin
				push_job.f0 = '{bits: {55'd0, 2'b10, dod_q[6:0]}, len: LEN_W'(9)};
			end else if ((&dod_q[DOD_W-1:8]) || !(|dod_q[DOD_W-1:8])) begin
				push_job.f0 = '{bits: {52'd0, 3'b110, dod_q[8:0]}, len: LEN_W'(12)};
			end else if ((&dod_q[DOD_W-1:11]) || !(|dod_q[DOD_W-1:11])) begin
				push_job.f0 = '{bits: {48'd0, 4'b1110, dod_q[11:0]}, len: LEN_W'(16)};
			end else begin
				push_job.f0 = '{bits: {28'd0, 4'b1111, dod_q[31:0]}, len: LEN_W'(36)};
			end
			priority if (x_zero_q) begin
				push_job.f1 = '{bits: '0, len: LEN_W'(1)};
				push_job.last_idx = 2'd1;
			end else if (win_hit) begin
				push_job.f1 = '{bits: {62'd0, 2'b10}, len: LEN_W'(2)};
				push_job.last_idx = 2'd2;
			end else begin
				push_job.f1 = '{bits: {50'd0, 2'b11, lz_q[5:0], len_q[5:0]}, len: LEN_W'(14)};
				push_job.last_idx = 2'd2;
			end
			push_job.f2 = '{bits: x_q >> tz_q, len: len_q};
			push_job.opens = 1'b0;
		end
	end

	// control and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_block_q <= 1'b0;
			block_start_q <= '0;
			prev_time_q <= '0;
			prev_delta_q <= '0;
			prev_value_q <= '0;
			win_valid_q <= 1'b0;
			win_lead_q <= '0;
			win_len_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (opens) begin
						state_q <= ST_DIV;
					end else begin
						prev_time_q <= t_q;
						prev_delta_q <= delta;
						prev_value_q <= v_q;
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (push_ready) begin
						if (!x_zero_q && !win_hit) begin
							win_valid_q <= 1'b1;
							win_lead_q <= lz_q[5:0];
							win_len_q <= len_q;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_OPEN;
				end
				ST_OPEN: begin
					if (push_ready) begin
						have_block_q <= 1'b1;
						block_start_q <= aligned;
						prev_time_q <= t_q;
						prev_delta_q <= {{(TIME_W+1-SPAN_W){1'b0}}, div_rem};
						prev_value_q <= v_q;
						win_valid_q <= 1'b0;
						win_lead_q <= '0;
						win_len_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-sample working registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			t_q <= timestamp;
			v_q <= value_bits;
		end
		if (state_q == ST_EVAL) begin
			dod_q <= dod;
			x_q <= v_q ^ prev_value_q;
			x_zero_q <= (v_q == prev_value_q);
		end
		if (state_q == ST_CNT) begin
			lz_q <= lz_c;
			tz_q <= tz_c;
			len_q <= LEN_W'(64) - lz_c - tz_c;
		end
	end

	`TDX_ASSERT_NEXT(a_div_to_open, clk, arst_n, (state_q == ST_DIV) && div_done, state_q == ST_OPEN)
	`TDX_ASSERT_IMPL(a_div_busy_in_div, clk, arst_n, state_q == ST_DIV, div_busy)
endmodule
`default_nettype wire

@@ rtl/tdx_queue.sv @@
// short job queue between the front and the field emitter
`timescale 1ns / 1ps
`default_nettype none
module tdx_queue #(
	parameter int DEPTH = tdx_pkg::QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire tdx_pkg::job_t push_job,
	output logic push_ready,
	input  wire logic pop,
	output logic head_valid,
	output tdx_pkg::job_t head
);
	import tdx_pkg::*;
	`include "timeseries_dod_xor_encoder_core_defines.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	`TDX_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(DEPTH))
	`TDX_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, cnt_q != '0)
	`TDX_ASSERT_IMPL(a_push_room, clk, arst_n, push, push_ready)
endmodule
`default_nettype wire

@@ rtl/tdx_emit.sv @@
// back part: sends job fields one per cycle while out_ready, to an output register
`timescale 1ns / 1ps
`default_nettype none
module tdx_emit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire tdx_pkg::job_t head,
	output logic pop,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [tdx_pkg::FIELD_W-1:0] field_bits,
	output logic [tdx_pkg::LEN_W-1:0] field_length,
	output logic opens_block,
	output logic last
);
	import tdx_pkg::*;
	`include "timeseries_dod_xor_encoder_core_defines.svh"

	logic [1:0] idx_q;
	logic out_valid_q;
	field_t out_field_q;
	logic opens_q;
	logic last_q;
	field_t sel;
	logic load;
	logic is_last;

	always_comb begin
		unique case (idx_q)
			2'd0: sel = head.f0;
			2'd1: sel = head.f1;
			default: sel = head.f2;
		endcase
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign is_last = (idx_q == head.last_idx);
	assign pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_field_q <= sel;
			opens_q <= head.opens;
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign field_bits = out_field_q.bits;
	assign field_length = out_field_q.len;
	assign opens_block = opens_q;
	assign last = last_q;

	`TDX_ASSERT_IMPL(a_idx_in_job, clk, arst_n, head_valid, idx_q <= head.last_idx)
endmodule
`default_nettype wire

@@ tb/tdx_field_checker.sv @@
// checker: follows the encoder state and compares every output field
`timescale 1ns / 1ps
module tdx_field_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [tdx_pkg::SPAN_W-1:0] cfg_data,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [95:0] s_axis_tdata,   // timestamp, value_bits
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [71:0] m_axis_tdata,   // field_bits, field_length, zero pad
	input wire logic m_axis_tuser,          // opens_block
	input wire logic m_axis_tlast,          // last
	output int mismatches,
	output int fields_pending
);
	typedef struct packed {
		logic [tdx_pkg::FIELD_W-1:0] bits;
		logic [tdx_pkg::LEN_W-1:0] len;
		logic opens;
		logic last;
	} coded_field_t;

	coded_field_t field_q[$];
	logic [tdx_pkg::SPAN_W-1:0] span_reg;
	logic have_block;
	logic [31:0] block_base;
	logic [31:0] last_time;
	longint last_delta;
	logic [63:0] last_value;
	logic win_valid;
	int win_lead;
	int win_len;

	function automatic void queue_field(input logic [63:0] bits, input logic [6:0] len,
			input logic opens, input logic last);
		coded_field_t f;
		f.bits = bits;
		f.len = len;
		f.opens = opens;
		f.last = last;
		field_q = {field_q, f};
	endfunction

	task automatic encode_sample(input logic [31:0] t, input logic [63:0] v);
		logic [31:0] span;
		logic [31:0] off;
		logic [31:0] aligned;
		longint delta;
		longint dod;
		logic [63:0] ud;
		logic [63:0] x;
		int lz;
		int tz;
		int len;
		span = (span_reg == '0) ? 32'd1 : {16'd0, span_reg};
		if (!have_block || (t - block_base) >= span) begin
			off = t % span;
			aligned = t - off;
			queue_field({32'd0, aligned}, 7'd64, 1'b1, 1'b0);
			queue_field({32'd0, off}, 7'd16, 1'b1, 1'b0);
			queue_field(v, 7'd64, 1'b1, 1'b1);
			have_block = 1'b1;
			block_base = aligned;
			last_time = t;
			last_delta = longint'({32'd0, off});
			last_value = v;
			win_valid = 1'b0;
			win_lead = 0;
			win_len = 0;
		end else begin
			delta = longint'({32'd0, t}) - longint'({32'd0, last_time});
			dod = delta - last_delta;
			ud = dod;
			last_delta = delta;
			last_time = t;
			if (dod == 0) begin
				queue_field(64'd0, 7'd1, 1'b0, 1'b0);
			end else if (dod >= -64 && dod <= 63) begin
				queue_field({55'd0, 2'b10, ud[6:0]}, 7'd9, 1'b0, 1'b0);
			end else if (dod >= -256 && dod <= 255) begin
				queue_field({52'd0, 3'b110, ud[8:0]}, 7'd12, 1'b0, 1'b0);
			end else if (dod >= -2048 && dod <= 2047) begin
				queue_field({48'd0, 4'b1110, ud[11:0]}, 7'd16, 1'b0, 1'b0);
			end else begin
				queue_field({28'd0, 4'b1111, ud[31:0]}, 7'd36, 1'b0, 1'b0);
			end
			x = v ^ last_value;
			if (x == 64'd0) begin
				queue_field(64'd0, 7'd1, 1'b0, 1'b1);
			end else begin
				lz = 0;
				while (lz < 64 && !x[63 - lz]) lz++;
				tz = 0;
				while (tz < 64 && !x[tz]) tz++;
				len = 64 - lz - tz;
				if (win_valid && lz == win_lead && len == win_len) begin
					queue_field(64'd2, 7'd2, 1'b0, 1'b0);
				end else begin
					// a length of 64 wraps to 0 in the six-bit field
					queue_field({50'd0, 2'b11, 6'(lz), 6'(len)}, 7'd14, 1'b0, 1'b0);
					win_valid = 1'b1;
					win_lead = lz;
					win_len = len;
				end
				queue_field(x >> tz, 7'(len), 1'b0, 1'b1);
				last_value = v;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		coded_field_t want;
		coded_field_t got;
		if (!arst_n) begin
			field_q.delete();
			span_reg = tdx_pkg::SPAN_RESET;
			have_block = 1'b0;
			block_base = '0;
			last_time = '0;
			last_delta = 0;
			last_value = '0;
			win_valid = 1'b0;
			win_lead = 0;
			win_len = 0;
			mismatches = 0;
			fields_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) span_reg = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				got.bits = m_axis_tdata[63:0];
				got.len = m_axis_tdata[70:64];
				got.opens = m_axis_tuser;
				got.last = m_axis_tlast;
				if (field_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected field: bits=%h len=%0d opens=%b last=%b",
							got.bits, got.len, got.opens, got.last);
				end else begin
					want = field_q.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("field mismatch: expected bits=%h len=%0d opens=%b last=%b,",
								want.bits, want.len, want.opens, want.last);
							$display(" got bits=%h len=%0d opens=%b last=%b",
								got.bits, got.len, got.opens, got.last);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				encode_sample(s_axis_tdata[31:0], s_axis_tdata[95:32]);
			fields_pending = field_q.size();
		end
	end
endmodule

@@ tb/timeseries_dod_xor_encoder_core_tb.sv @@
// testbench top: sample stimulus, output stalls and the verdict for the encoder
`timescale 1ns / 1ps
module timeseries_dod_xor_encoder_core_tb;
	localparam int CYCLE_LIMIT = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = 16'd0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;     // timestamp, value_bits
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;          // field_bits, field_length, zero pad
	logic m_axis_tuser;                 // opens_block
	logic m_axis_tlast;                 // last
	int mismatches;
	int fields_pending;
	int cycle_count = 0;
	logic steady = 1'b0;
	logic [31:0] now_t = '0;
	logic [63:0] now_v = '0;
	int step_base = 10;
	int shape_lead = 0;
	int shape_len = 1;

	always #6 clk = ~clk;

	timeseries_dod_xor_encoder_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	tdx_field_checker i_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.mismatches(mismatches),
		.fields_pending(fields_pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeseries_dod_xor_encoder_core regression: fail");
			$finish;
		end
	end

	task automatic send_sample(input logic [31:0] t, input logic [63:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		now_t = t;
		now_v = v;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {v, t};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic push_delta(input int d, input logic [63:0] v);
		send_sample(now_t + d, v);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (fields_pending != 0) @(posedge clk);
	endtask

	task automatic write_span(input logic [15:0] span);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= span;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] next_time();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5) return $urandom;
		if (pick < 45) return now_t + step_base;
		if (pick < 70) return now_t + step_base + $urandom_range(0, 126) - 63;
		if (pick < 85) return now_t + step_base + $urandom_range(0, 510) - 255;
		if (pick < 95) return now_t + step_base + $urandom_range(0, 4094) - 2047;
		return now_t + $urandom_range(0, 40000);
	endfunction

	function automatic logic [63:0] next_value();
		logic [63:0] m;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) return now_v;
		if (pick < 35) return {$urandom, $urandom};
		if (pick >= 95) begin
			shape_lead = 0;
			shape_len = 64;
		end else if (pick >= 70) begin
			shape_lead = $urandom_range(0, 63);
			shape_len = $urandom_range(1, 64 - shape_lead);
		end
		// random bits inside the window, both window ends set
		m = {$urandom, $urandom} & (64'hFFFF_FFFF_FFFF_FFFF >> shape_lead);
		m = m & ~((64'd1 << (64 - shape_lead - shape_len)) - 64'd1);
		m[63 - shape_lead] = 1'b1;
		m[64 - shape_lead - shape_len] = 1'b1;
		return now_v ^ m;
	endfunction

	task automatic random_phase(input logic [15:0] span, input int count);
		int n;
		write_span(span);
		while (count > 0) begin
			n = $urandom_range(8, 30);
			if (n > count) n = count;
			if ($urandom_range(0, 3) == 0) now_t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			else now_t = $urandom;
			step_base = $urandom_range(1, 90);
			steady = ($urandom_range(0, 3) == 0);
			repeat (n) send_sample(next_time(), next_value());
			count -= n;
		end
	endtask

	initial begin : sink
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// delta-of-delta bucket edges inside one block at the reset span
		send_sample(32'd7200, 64'd0);
		push_delta(63, 64'd0);
		push_delta(-1, 64'd1);
		push_delta(63, 64'd0);
		push_delta(318, 64'h8000_0000_0000_0000);
		push_delta(62, 64'h7FFF_FFFF_FFFF_FFFF);
		push_delta(318, 64'h8000_0000_0000_0000);
		push_delta(2365, 64'hFFFF_FFFF_FFFF_FFFF);
		push_delta(317, 64'hFFFF_FFFF_FFFF_FFFF);
		push_delta(2365, 64'h0123_4567_89AB_CDEF);
		push_delta(316, 64'h0123_4567_89AB_CDEF ^ 64'h0000_0FF0_0000_0000);
		push_delta(316, 64'h0123_4567_89AB_CDEF ^ 64'h0000_0FF0_0000_0000
			^ 64'h0000_0810_0000_0000);
		// exactly one span after the block start
		push_delta(698, 64'hFFFF_FFFF_FFFF_FFFF);
		// block across the 32-bit wrap, then a sample before the block start
		send_sample(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_sample(32'd5, 64'd0);
		send_sample(32'd0, 64'd0);
		send_sample(32'd4294965599, 64'h5555_5555_5555_5555);
		send_sample(32'd0, 64'hAAAA_AAAA_AAAA_AAAA);

		random_phase(16'd7200, 60);
		random_phase(16'd1, 50);
		random_phase(16'd0, 50);
		random_phase(16'hFFFF, 70);
		random_phase(16'd60, 60);
		random_phase(16'($urandom_range(2, 65534)), 60);
		random_phase(tdx_pkg::SPAN_RESET, 50);

		settle();
		steady = 1'b0;
		repeat (50) @(posedge clk);
		if (mismatches == 0 && fields_pending == 0)
			$display("timeseries_dod_xor_encoder_core regression: pass");
		else
			$display("timeseries_dod_xor_encoder_core regression: fail");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/tdx_pkg.sv
rtl/tdx_div.sv
rtl/tdx_front.sv
rtl/tdx_queue.sv
rtl/tdx_emit.sv
rtl/timeseries_dod_xor_encoder_core.sv
tb/tdx_field_checker.sv
tb/timeseries_dod_xor_encoder_core_tb.sv
